>>> rtl/ufmt_pkg.sv
// ----------------------------------------------------------------------------
// ufmt_pkg
// Shared types and constants of the unsigned decimal field formatter.
// ----------------------------------------------------------------------------
package ufmt_pkg;

   localparam int NUM_DIGITS = 10;   // decimal digits of a 32-bit value
   localparam int VALUE_BITS = 32;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [3:0] RADIX    = 4'd10;

   typedef struct packed {
      logic [31:0] value;
      logic        has_precision;
      logic [6:0]  precision;
      logic [6:0]  width;
      logic        left_align;
      logic        zero_pad;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic [6:0] total_count;
   } rsp_type;

   typedef logic [NUM_DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic load;       // capture the accepted item
      logic conv_step;  // one shift-and-adjust step of the conversion
      logic size;       // latch digit count and field lengths
      logic emit;       // send the character at the current position
   } cmd_type;

   typedef struct packed {
      logic conv_last;  // this conversion step is the final one
      logic emit_last;  // the current character ends the field
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIZE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

>>> rtl/unsigned_decimal_field_formatter_unit.sv
// The first character reaches the result ports after the 32 conversion steps, the sizing
// state and the output register; further characters follow one a cycle. A new item is
// accepted only after all characters of the field (0..64) are sent, since the 32-step
// shift-and-add-3 conversion and the one-character output run in turn.
// Reset: synchronous, active high; returns the controller to idle and drops
// the result strobe. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter_unit
// Formats a 32-bit unsigned value as a padded decimal field, at most one ASCII
// character per result item.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter_unit
   import ufmt_pkg::*;
#(
   parameter int MAX_FIELD = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   ufmt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ufmt_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !rsp_strobe)
      else $error("result strobe continued after the last item");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.byte_valid |-> rsp_item.last && rsp_item.total_count == 7'd0)
      else $error("empty-field item not marked last with zero count");

   a_count_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> rsp_item.total_count == 7'd0)
      else $error("count shown before the last item");

endmodule

>>> rtl/ufmt_ctrl.sv
// ----------------------------------------------------------------------------
// ufmt_ctrl
// Controller: sequences load, conversion, sizing and character output.
// ----------------------------------------------------------------------------
module ufmt_ctrl
   import ufmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_last) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/ufmt_datapath.sv
// ----------------------------------------------------------------------------
// ufmt_datapath
// Datapath: shift-and-add-3 binary to BCD conversion, field sizing and
// character selection with a registered result.
// ----------------------------------------------------------------------------
module ufmt_datapath
   import ufmt_pkg::*;
#(
   parameter int MAX_FIELD = 64
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_item
);

   localparam logic [6:0] MAX_LEN = 7'(MAX_FIELD);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   bcd_type               bcd_ff, bcd_in, bcd_adj;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  dot_ff, left_ff, zflag_ff;
   logic [6:0]            prec_ff, wid_ff;
   logic [3:0]            ndig_ff, ndig_in;
   logic [6:0]            body_ff, body_in, total_ff, total_in;
   logic [6:0]            k_ff;
   logic                  strobe_ff;
   rsp_type               rsp_ff, rsp_in;

   // adjust each BCD digit before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
      cnt_in = cnt_ff + 5'd1;
   end

   // digit count and field lengths
   always_comb begin
      logic any_nz;
      any_nz  = 1'b0;
      ndig_in = 4'd1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            ndig_in = 4'(i + 1);
            any_nz  = 1'b1;
         end
      end
      // zero precision with zero value prints no digits
      if (dot_ff && prec_ff == 7'd0 && !any_nz) begin
         ndig_in = 4'd0;
      end
      body_in  = (dot_ff && prec_ff > {3'd0, ndig_in}) ? prec_ff : {3'd0, ndig_in};
      total_in = (wid_ff > body_in) ? wid_ff : body_in;
   end

   // character at position k
   always_comb begin
      logic [6:0] base;
      logic [6:0] r;
      logic [7:0] padch;
      base  = left_ff ? body_ff : total_ff;
      r     = base - 7'd1 - k_ff;
      padch = (zflag_ff && !dot_ff && !left_ff) ? CH_ZERO : CH_SPACE;
      rsp_in = '0;
      if (total_ff == 7'd0) begin
         rsp_in.last = 1'b1;
      end else begin
         rsp_in.byte_valid = 1'b1;
         if (left_ff && k_ff >= body_ff) begin
            rsp_in.out_byte = CH_SPACE;
         end else if (r < {3'd0, ndig_ff}) begin
            rsp_in.out_byte = CH_ZERO + {4'd0, bcd_ff[r[3:0]]};
         end else if (r < body_ff) begin
            rsp_in.out_byte = CH_ZERO;
         end else begin
            rsp_in.out_byte = padch;
         end
         if (k_ff == total_ff - 7'd1) begin
            rsp_in.last        = 1'b1;
            rsp_in.total_count = total_ff;
         end
      end
   end

   assign status.conv_last = (cnt_ff == 5'd31);
   assign status.emit_last = (total_ff == 7'd0) || (k_ff == total_ff - 7'd1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff   <= req_item.value;
         bcd_ff   <= '0;
         cnt_ff   <= '0;
         dot_ff   <= req_item.has_precision;
         left_ff  <= req_item.left_align;
         zflag_ff <= req_item.zero_pad;
         prec_ff  <= (req_item.precision > MAX_LEN) ? MAX_LEN : req_item.precision;
         wid_ff   <= (req_item.width > MAX_LEN) ? MAX_LEN : req_item.width;
      end
      if (cmd.conv_step) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
         cnt_ff <= cnt_in;
      end
      if (cmd.size) begin
         ndig_ff  <= ndig_in;
         body_ff  <= body_in;
         total_ff <= total_in;
         k_ff     <= '0;
      end
      if (cmd.emit) begin
         k_ff   <= k_ff + 7'd1;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
